// ----- sv/etl_pkg.sv -----
`default_nettype none
package etl_pkg;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_AXIS = 2'd1;
    localparam logic [1:0] ST_INSIDE   = 2'd2;
    localparam logic [1:0] ST_DEGEN    = 2'd3;

    // one root bit per sqrt stage, one quotient bit per divide stage
    localparam int SQRT_STEPS = 32;
    localparam int UNIT_FRAC  = 30;
    localparam int LANES      = 4;

    // per-word context that rides along the whole pipe
    typedef struct packed {
        logic [1:0]         status;
        logic               nx;
        logic               ny;
        logic [30:0]        a;
        logic [30:0]        b;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } ctx_t;

    // sideband through the square root
    typedef struct packed {
        ctx_t        ctx;
        logic [30:0] w;
        logic [30:0] mx;
        logic [30:0] my;
        logic [62:0] n;
    } sq_side_t;

    // sideband through the divider
    typedef struct packed {
        ctx_t             ctx;
        logic [LANES-1:0] neg;
        logic [62:0]      den;
    } dv_side_t;

endpackage
`default_nettype wire

// ----- sv/etl_sqrt.sv -----
`default_nettype none
module etl_sqrt
    import etl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_vld,
    input  wire logic [63:0] in_rad,
    input  wire sq_side_t    in_side,
    output logic             out_vld,
    output logic [31:0]      out_root,
    output sq_side_t         out_side
);

    logic        vld_reg  [SQRT_STEPS];
    logic [63:0] rad_reg  [SQRT_STEPS];
    logic [63:0] root_reg [SQRT_STEPS];
    sq_side_t    side_reg [SQRT_STEPS];

    // restoring square root, one result bit per stage
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic        v_in;
        logic [63:0] rad_in;
        logic [63:0] root_in;
        sq_side_t    s_in;
        logic [63:0] trial;
        logic [63:0] rad_next;
        logic [63:0] root_next;

        if (g == 0) begin : g_first
            assign v_in    = in_vld;
            assign rad_in  = in_rad;
            assign root_in = 64'd0;
            assign s_in    = in_side;
        end
        else begin : g_rest
            assign v_in    = vld_reg[g-1];
            assign rad_in  = rad_reg[g-1];
            assign root_in = root_reg[g-1];
            assign s_in    = side_reg[g-1];
        end

        always_comb
        begin
            trial = root_in + BIT;
            if (rad_in >= trial)
            begin
                rad_next  = rad_in - trial;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                rad_next  = rad_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[g]  <= rad_next;
            root_reg[g] <= root_next;
            side_reg[g] <= s_in;
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign out_root = root_reg[SQRT_STEPS-1][31:0];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ----- sv/etl_div.sv -----
`default_nettype none
module etl_div
    import etl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_vld,
    input  wire logic [63:0] in_rem [LANES],
    input  wire logic [30:0] in_quo [LANES],
    input  wire dv_side_t    in_side,
    output logic             out_vld,
    output logic [30:0]      out_quo [LANES],
    output dv_side_t         out_side
);

    logic        vld_reg  [UNIT_FRAC];
    logic [63:0] rem_reg  [UNIT_FRAC][LANES];
    logic [30:0] quo_reg  [UNIT_FRAC][LANES];
    dv_side_t    side_reg [UNIT_FRAC];

    // restoring fraction divide, four lanes share the denominator
    for (genvar g = 0; g < UNIT_FRAC; g++) begin : g_step
        logic        v_in;
        logic [63:0] rem_in  [LANES];
        logic [30:0] quo_in  [LANES];
        dv_side_t    s_in;
        logic [63:0] rem_next [LANES];
        logic [30:0] quo_next [LANES];
        logic [63:0] den;

        if (g == 0) begin : g_first
            assign v_in   = in_vld;
            assign rem_in = in_rem;
            assign quo_in = in_quo;
            assign s_in   = in_side;
        end
        else begin : g_rest
            assign v_in   = vld_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign s_in   = side_reg[g-1];
        end

        assign den = {1'b0, s_in.den};

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[l] = rem_in[l] << 1;
                quo_next[l] = quo_in[l] << 1;
                if (rem_next[l] >= den)
                begin
                    rem_next[l]    = rem_next[l] - den;
                    quo_next[l][0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            quo_reg[g]  <= quo_next;
            side_reg[g] <= s_in;
        end
    end

    assign out_vld  = vld_reg[UNIT_FRAC-1];
    assign out_quo  = quo_reg[UNIT_FRAC-1];
    assign out_side = side_reg[UNIT_FRAC-1];

endmodule
`default_nettype wire

// ----- sv/ellipse_tangent_points.sv -----
// start passes s1 to s7, the square root, s8, s9, the divider, s10 and s11 to done.
// Throughput: one word per cycle; busy is always low, the pipe never stalls.
// Depth is set by the 32-stage square root and the 30-stage fraction divider.
// Reset clears only the valid bits; a result is never held back by the receiver.
`default_nettype none
module ellipse_tangent_points
    import etl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic [30:0]        semi_axis_a,
    input  wire logic [30:0]        semi_axis_b,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      touch1_x,
    output logic signed [31:0]      touch1_y,
    output logic signed [31:0]      touch2_x,
    output logic signed [31:0]      touch2_y
);

    function automatic logic signed [64:0] with_sign(input logic [62:0] mag, input logic neg);
        logic signed [64:0] v;
        v = $signed({2'b00, mag});
        return neg ? -v : v;
    endfunction

    assign busy = 1'b0;

    // ---- s1: offsets and early status
    logic               v1_reg;
    ctx_t               c1_reg;
    logic [32:0]        dxm1_reg;
    logic [32:0]        dym1_reg;
    logic signed [32:0] dx_next;
    logic signed [32:0] dy_next;
    ctx_t               c1_next;

    always_comb
    begin
        dx_next        = 33'(point_x) - 33'(center_x);
        dy_next        = 33'(point_y) - 33'(center_y);
        c1_next.a      = semi_axis_a;
        c1_next.b      = semi_axis_b;
        c1_next.cx     = center_x;
        c1_next.cy     = center_y;
        c1_next.nx     = dx_next[32];
        c1_next.ny     = dy_next[32];
        if (semi_axis_a == 31'd0 || semi_axis_b == 31'd0)
            c1_next.status = ST_BAD_AXIS;
        else if (dx_next == 33'sd0)
            c1_next.status = ST_DEGEN;
        else
            c1_next.status = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        c1_reg   <= c1_next;
        dxm1_reg <= dx_next[32] ? 33'(-dx_next) : 33'(dx_next);
        dym1_reg <= dy_next[32] ? 33'(-dy_next) : 33'(dy_next);
    end

    // ---- s2: scale to the unit circle
    logic        v2_reg;
    ctx_t        c2_reg;
    logic [63:0] mx2_reg;
    logic [63:0] my2_reg;
    logic [63:0] w2_reg;

    always_ff @(posedge clk)
    begin
        c2_reg  <= c1_reg;
        mx2_reg <= 64'(dxm1_reg) * 64'(c1_reg.b);
        my2_reg <= 64'(dym1_reg) * 64'(c1_reg.a);
        w2_reg  <= 64'(c1_reg.a) * 64'(c1_reg.b);
    end

    // ---- s3: largest magnitude
    logic        v3_reg;
    ctx_t        c3_reg;
    logic [63:0] mx3_reg;
    logic [63:0] my3_reg;
    logic [63:0] w3_reg;
    logic [63:0] m3_reg;
    logic [63:0] m_next;

    always_comb
    begin
        m_next = mx2_reg;
        if (my2_reg > m_next)
            m_next = my2_reg;
        if (w2_reg > m_next)
            m_next = w2_reg;
    end

    always_ff @(posedge clk)
    begin
        c3_reg  <= c2_reg;
        mx3_reg <= mx2_reg;
        my3_reg <= my2_reg;
        w3_reg  <= w2_reg;
        m3_reg  <= m_next;
    end

    // ---- s4: normalizing shift from the leading one
    logic        v4_reg;
    ctx_t        c4_reg;
    logic [63:0] mx4_reg;
    logic [63:0] my4_reg;
    logic [63:0] w4_reg;
    logic [5:0]  sh4_reg;
    logic [5:0]  sh_next;

    always_comb
    begin
        sh_next = 6'd0;
        for (int i = 31; i < 64; i++)
        begin
            if (m3_reg[i])
                sh_next = 6'(i - 30);
        end
    end

    always_ff @(posedge clk)
    begin
        c4_reg  <= c3_reg;
        mx4_reg <= mx3_reg;
        my4_reg <= my3_reg;
        w4_reg  <= w3_reg;
        sh4_reg <= sh_next;
    end

    // ---- s5: apply shift
    logic        v5_reg;
    ctx_t        c5_reg;
    logic [30:0] mx5_reg;
    logic [30:0] my5_reg;
    logic [30:0] w5_reg;

    always_ff @(posedge clk)
    begin
        c5_reg  <= c4_reg;
        mx5_reg <= 31'(mx4_reg >> sh4_reg);
        my5_reg <= 31'(my4_reg >> sh4_reg);
        w5_reg  <= 31'(w4_reg >> sh4_reg);
    end

    // ---- s6: squares
    logic        v6_reg;
    ctx_t        c6_reg;
    logic [30:0] mx6_reg;
    logic [30:0] my6_reg;
    logic [30:0] w6_reg;
    logic [61:0] xx6_reg;
    logic [61:0] yy6_reg;
    logic [61:0] ww6_reg;

    always_ff @(posedge clk)
    begin
        c6_reg  <= c5_reg;
        mx6_reg <= mx5_reg;
        my6_reg <= my5_reg;
        w6_reg  <= w5_reg;
        xx6_reg <= 62'(mx5_reg) * 62'(mx5_reg);
        yy6_reg <= 62'(my5_reg) * 62'(my5_reg);
        ww6_reg <= 62'(w5_reg) * 62'(w5_reg);
    end

    // ---- s7: norm, inside test, radicand
    logic        v7_reg;
    sq_side_t    s7_reg;
    logic [63:0] rad7_reg;
    logic [62:0] n_next;
    sq_side_t    s7_next;

    always_comb
    begin
        n_next     = 63'(xx6_reg) + 63'(yy6_reg);
        s7_next.ctx = c6_reg;
        s7_next.w  = w6_reg;
        s7_next.mx = mx6_reg;
        s7_next.my = my6_reg;
        s7_next.n  = n_next;
        if (c6_reg.status == ST_OK && n_next <= 63'(ww6_reg))
            s7_next.ctx.status = ST_INSIDE;
    end

    always_ff @(posedge clk)
    begin
        s7_reg   <= s7_next;
        rad7_reg <= 64'(n_next - 63'(ww6_reg));
    end

    // ---- square root
    logic        sq_vld;
    logic [31:0] sq_root;
    sq_side_t    sq_side;

    etl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (v7_reg),
        .in_rad   (rad7_reg),
        .in_side  (s7_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ---- s8: numerator products
    logic        v8_reg;
    sq_side_t    s8_reg;
    logic [62:0] wx8_reg;
    logic [62:0] wy8_reg;
    logic [62:0] qx8_reg;
    logic [62:0] qy8_reg;

    always_ff @(posedge clk)
    begin
        s8_reg  <= sq_side;
        wx8_reg <= 63'(sq_side.w) * 63'(sq_side.mx);
        wy8_reg <= 63'(sq_side.w) * 63'(sq_side.my);
        qx8_reg <= 63'(sq_root) * 63'(sq_side.mx);
        qy8_reg <= 63'(sq_root) * 63'(sq_side.my);
    end

    // ---- s9: signed numerators, magnitude, clamp, first quotient bit
    logic               v9_reg;
    dv_side_t           d9_reg;
    logic [63:0]        rem9_reg [LANES];
    logic [30:0]        quo9_reg [LANES];
    logic signed [64:0] num      [LANES];
    logic [63:0]        mag      [LANES];
    logic [63:0]        den9;
    logic [63:0]        rem_next [LANES];
    logic [30:0]        quo_next [LANES];
    dv_side_t           d9_next;
    logic               sqy;

    always_comb
    begin
        sqy    = s8_reg.ctx.nx ^ s8_reg.ctx.ny;
        num[0] = with_sign(wx8_reg, s8_reg.ctx.nx) - with_sign(qy8_reg, sqy);
        num[1] = with_sign(wy8_reg, s8_reg.ctx.ny) + with_sign(qx8_reg, 1'b0);
        num[2] = with_sign(wx8_reg, s8_reg.ctx.nx) + with_sign(qy8_reg, sqy);
        num[3] = with_sign(wy8_reg, s8_reg.ctx.ny) - with_sign(qx8_reg, 1'b0);
        den9   = {1'b0, s8_reg.n};
        d9_next.ctx = s8_reg.ctx;
        d9_next.den = s8_reg.n;
        for (int l = 0; l < LANES; l++)
        begin
            d9_next.neg[l] = num[l][64];
            mag[l] = num[l][64] ? 64'(-num[l]) : 64'(num[l]);
            if (mag[l] >= den9)
            begin
                rem_next[l] = 64'd0;
                quo_next[l] = 31'd1;
            end
            else
            begin
                rem_next[l] = mag[l];
                quo_next[l] = 31'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d9_reg   <= d9_next;
        rem9_reg <= rem_next;
        quo9_reg <= quo_next;
    end

    // ---- fraction divide
    logic        dv_vld;
    logic [30:0] dv_quo [LANES];
    dv_side_t    dv_side;

    etl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (v9_reg),
        .in_rem   (rem9_reg),
        .in_quo   (quo9_reg),
        .in_side  (d9_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // ---- s10: back to ellipse scale
    logic        v10_reg;
    dv_side_t    d10_reg;
    logic [31:0] off10_reg [LANES];
    logic [61:0] prod      [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (l % 2 == 0)
                prod[l] = 62'(dv_side.ctx.a) * 62'(dv_quo[l]);
            else
                prod[l] = 62'(dv_side.ctx.b) * 62'(dv_quo[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        d10_reg <= dv_side;
        for (int l = 0; l < LANES; l++)
            off10_reg[l] <= prod[l][UNIT_FRAC +: 32];
    end

    // ---- s11: add to centre, saturate, zero on error
    logic               done_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] touch_reg [LANES];
    logic signed [33:0] sum       [LANES];
    logic signed [31:0] sat_next  [LANES];
    logic signed [33:0] ctr;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ctr = (l % 2 == 0) ? 34'(d10_reg.ctx.cx) : 34'(d10_reg.ctx.cy);
            if (d10_reg.neg[l])
                sum[l] = ctr - $signed({2'b00, off10_reg[l]});
            else
                sum[l] = ctr + $signed({2'b00, off10_reg[l]});
            if (d10_reg.ctx.status != ST_OK)
                sat_next[l] = 32'sd0;
            else if (sum[l] > 34'sd2147483647)
                sat_next[l] = 32'sh7FFFFFFF;
            else if (sum[l] < -34'sd2147483648)
                sat_next[l] = 32'sh80000000;
            else
                sat_next[l] = 32'(sum[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= d10_reg.ctx.status;
        touch_reg  <= sat_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= sq_vld;
            v9_reg   <= v8_reg;
            v10_reg  <= dv_vld;
            done_reg <= v10_reg;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign touch1_x = touch_reg[0];
    assign touch1_y = touch_reg[1];
    assign touch2_x = touch_reg[2];
    assign touch2_y = touch_reg[3];

endmodule
`default_nettype wire
